>>> src/rds_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, constants and pipeline stage numbers of the radial distortion scaler.
package rds_pkg;

    // Coordinate format: signed Q4.F.
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = COORD_WIDTH - 4;

    // Sum of squares and its alignment to 24 fraction bits.
    localparam int SUMSQ_WIDTH = 2 * COORD_WIDTH;
    localparam int S24_SHIFT   = 2 * FRAC_BITS - 24;
    localparam int S24_WIDTH   = 32;

    // Kappa and the product kappa * s24.
    localparam int KAPPA_WIDTH = 32;
    localparam int KPROD_WIDTH = 2 * KAPPA_WIDTH;
    localparam int M_SHIFT     = 17;
    localparam int MMAG_WIDTH  = KPROD_WIDTH - M_SHIFT;

    // d = 1 - m in Q.30, always positive.
    localparam int D_WIDTH = MMAG_WIDTH;
    localparam logic [D_WIDTH-1:0] ONE_Q30 = D_WIDTH'(1) << 30;
    localparam logic [D_WIDTH-1:0] M_CLAMP = D_WIDTH'(1068373115);

    // Square root of d * 2^14, one result bit per stage.
    localparam int RAD_PRESHIFT = 14;
    localparam int SQ_STEPS     = 31;
    localparam int RAD_WIDTH    = 2 * SQ_STEPS;
    localparam int ROOT_WIDTH   = SQ_STEPS;
    localparam int SQREM_WIDTH  = ROOT_WIDTH + 3;

    // Reciprocal f = (2^50 + g/2) / g, one quotient bit per stage.
    localparam int RECIP_SHIFT = 50;
    localparam int Q_WIDTH     = 32;
    localparam int DVREM_WIDTH = ROOT_WIDTH + 1;

    // Final scaling by f in Q.28 with rounding.
    localparam int PROD_WIDTH = COORD_WIDTH + Q_WIDTH;
    localparam int OUT_SHIFT  = 28;

    // Pipeline stage numbers, counted from the input register.
    localparam int STG_E   = 4;
    localparam int STG_DIV = STG_E + SQ_STEPS + 1;
    localparam int STG_M   = STG_DIV + Q_WIDTH + 1;
    localparam int STG_R   = STG_M + 1;
    localparam int LATENCY = STG_R + 1;

    // Configuration port.
    localparam int ADDR_WIDTH = 3;
    localparam logic REG_KAPPA = 1'b0;

    typedef struct packed {
        logic                          req_type;
        logic signed [COORD_WIDTH-1:0] x_in;
        logic signed [COORD_WIDTH-1:0] y_in;
    } req_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
        logic                          radius_clamped;
        logic                          coord_saturated;
    } res_t;

endpackage

>>> src/rds_datapath.sv
`timescale 1ns / 1ps
// Pipelined datapath: radius, square root, reciprocal and saturating scale.
module rds_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  rds_pkg::req_t                      req,
    input  logic signed [rds_pkg::KAPPA_WIDTH-1:0] kappa,
    output logic                               result_valid,
    output rds_pkg::res_t                      result
);
    import rds_pkg::*;

    // Side information travelling with each beat.
    logic                          vld_reg [0:STG_M];
    logic signed [COORD_WIDTH-1:0] sx_reg  [0:STG_M];
    logic signed [COORD_WIDTH-1:0] sy_reg  [0:STG_M];
    logic                          kz_reg  [0:STG_M];
    logic                          cl_reg  [STG_E:STG_M];

    // Front stages.
    logic                          a_kneg_reg;
    logic [KAPPA_WIDTH-1:0]        a_kmag_reg;
    logic [COORD_WIDTH-1:0]        a_ux_reg, a_uy_reg;
    logic                          b_kneg_reg;
    logic [KAPPA_WIDTH-1:0]        b_kmag_reg;
    logic [SUMSQ_WIDTH-1:0]        b_sqx_reg, b_sqy_reg;
    logic                          c_kneg_reg;
    logic [KAPPA_WIDTH-1:0]        c_kmag_reg;
    logic [S24_WIDTH-1:0]          c_s24_reg;
    logic                          d_kneg_reg;
    logic [KPROD_WIDTH-1:0]        d_kprod_reg;

    logic [COORD_WIDTH-1:0]        in_ux, in_uy;
    logic [KAPPA_WIDTH-1:0]        in_kmag;
    logic [SUMSQ_WIDTH-1:0]        c_sum;
    logic [S24_WIDTH-1:0]          c_s24_next;
    logic [MMAG_WIDTH-1:0]         e_mm;
    logic [D_WIDTH-1:0]            e_d;
    logic                          e_clamp;

    // Square root stages.
    logic [RAD_WIDTH-1:0]          sq_rad_reg  [0:SQ_STEPS];
    logic [SQREM_WIDTH-1:0]        sq_rem_reg  [0:SQ_STEPS];
    logic [ROOT_WIDTH-1:0]         sq_root_reg [0:SQ_STEPS];
    logic [RAD_WIDTH-1:0]          sq_rad_next  [1:SQ_STEPS];
    logic [SQREM_WIDTH-1:0]        sq_rem_next  [1:SQ_STEPS];
    logic [ROOT_WIDTH-1:0]         sq_root_next [1:SQ_STEPS];
    logic [SQREM_WIDTH-1:0]        sq_sh   [1:SQ_STEPS];
    logic [SQREM_WIDTH-1:0]        sq_trial[1:SQ_STEPS];

    // Divider stages.
    logic [DVREM_WIDTH-1:0]        dv_rem_reg [0:Q_WIDTH];
    logic [Q_WIDTH-1:0]            dv_num_reg [0:Q_WIDTH];
    logic [Q_WIDTH-1:0]            dv_q_reg   [0:Q_WIDTH];
    logic [ROOT_WIDTH-1:0]         dv_g_reg   [0:Q_WIDTH];
    logic [DVREM_WIDTH-1:0]        dv_rem_next [1:Q_WIDTH];
    logic [Q_WIDTH-1:0]            dv_num_next [1:Q_WIDTH];
    logic [Q_WIDTH-1:0]            dv_q_next   [1:Q_WIDTH];
    logic [DVREM_WIDTH-1:0]        dv_sh       [1:Q_WIDTH];

    // Scaling stages.
    logic [PROD_WIDTH-1:0]         m_px_reg, m_py_reg;
    logic [COORD_WIDTH-1:0]        m_ux, m_uy;
    logic                          res_vld_reg;
    res_t                          res_reg;
    logic [COORD_WIDTH:0]          r_x, r_y;

    // Rounds |c| * f back to Q4.F, restores the sign and saturates; top bit flags saturation.
    function automatic logic [COORD_WIDTH:0] scale_sat(input logic [PROD_WIDTH-1:0] prod,
                                                       input logic neg);
        logic [PROD_WIDTH:0]    rounded;
        logic [PROD_WIDTH:0]    p;
        logic [PROD_WIDTH:0]    lim;
        logic [COORD_WIDTH-1:0] v;
        logic                   sat;
        rounded = (PROD_WIDTH + 1)'(prod) + ((PROD_WIDTH + 1)'(1) << (OUT_SHIFT - 1));
        p       = rounded >> OUT_SHIFT;
        lim     = (PROD_WIDTH + 1)'(1) << (COORD_WIDTH - 1);
        sat     = 1'b0;
        if (neg) begin
            if (p > lim) begin
                sat = 1'b1;
                v   = COORD_WIDTH'(lim);
            end else begin
                v = COORD_WIDTH'(~p + 1'b1);
            end
        end else begin
            if (p > lim - 1'b1) begin
                sat = 1'b1;
                v   = COORD_WIDTH'(lim - 1'b1);
            end else begin
                v = COORD_WIDTH'(p);
            end
        end
        return {sat, v};
    endfunction

    // Magnitudes at the input.
    always_comb
    begin
        in_ux   = req.x_in[COORD_WIDTH-1] ? COORD_WIDTH'(-req.x_in) : COORD_WIDTH'(req.x_in);
        in_uy   = req.y_in[COORD_WIDTH-1] ? COORD_WIDTH'(-req.y_in) : COORD_WIDTH'(req.y_in);
        in_kmag = kappa[KAPPA_WIDTH-1] ? KAPPA_WIDTH'(-kappa) : KAPPA_WIDTH'(kappa);
    end

    // Align the sum of squares to 24 fraction bits.
    assign c_sum = b_sqx_reg + b_sqy_reg;
    generate
        if (S24_SHIFT >= 0)
        begin : g_shr
            assign c_s24_next = S24_WIDTH'(c_sum >> S24_SHIFT);
        end
        else
        begin : g_shl
            assign c_s24_next = S24_WIDTH'(c_sum) << (-S24_SHIFT);
        end
    endgenerate

    // m = 2*k*s, clamped from above, and d = 1 - m.
    always_comb
    begin
        e_mm    = d_kprod_reg[KPROD_WIDTH-1:M_SHIFT];
        e_clamp = 1'b0;
        if (d_kneg_reg) begin
            e_d = ONE_Q30 + e_mm;
        end else if (e_mm >= M_CLAMP) begin
            e_d     = ONE_Q30 - M_CLAMP;
            e_clamp = 1'b1;
        end else begin
            e_d = ONE_Q30 - e_mm;
        end
    end

    // One root bit per stage.
    always_comb
    begin
        for (int j = 1; j <= SQ_STEPS; j++) begin
            sq_sh[j]    = {sq_rem_reg[j-1][SQREM_WIDTH-3:0], sq_rad_reg[j-1][RAD_WIDTH-1 -: 2]};
            sq_trial[j] = SQREM_WIDTH'({sq_root_reg[j-1], 2'b01});
            sq_rad_next[j] = sq_rad_reg[j-1] << 2;
            if (sq_sh[j] >= sq_trial[j]) begin
                sq_rem_next[j]  = sq_sh[j] - sq_trial[j];
                sq_root_next[j] = {sq_root_reg[j-1][ROOT_WIDTH-2:0], 1'b1};
            end else begin
                sq_rem_next[j]  = sq_sh[j];
                sq_root_next[j] = {sq_root_reg[j-1][ROOT_WIDTH-2:0], 1'b0};
            end
        end
    end

    // One quotient bit per stage.
    always_comb
    begin
        for (int j = 1; j <= Q_WIDTH; j++) begin
            dv_sh[j]       = {dv_rem_reg[j-1][DVREM_WIDTH-2:0], dv_num_reg[j-1][Q_WIDTH-1]};
            dv_num_next[j] = dv_num_reg[j-1] << 1;
            if (dv_sh[j] >= DVREM_WIDTH'(dv_g_reg[j-1])) begin
                dv_rem_next[j] = dv_sh[j] - DVREM_WIDTH'(dv_g_reg[j-1]);
                dv_q_next[j]   = {dv_q_reg[j-1][Q_WIDTH-2:0], 1'b1};
            end else begin
                dv_rem_next[j] = dv_sh[j];
                dv_q_next[j]   = {dv_q_reg[j-1][Q_WIDTH-2:0], 1'b0};
            end
        end
    end

    // Magnitudes for the final scaling.
    always_comb
    begin
        m_ux = sx_reg[STG_M-1][COORD_WIDTH-1] ? COORD_WIDTH'(-sx_reg[STG_M-1])
                                              : COORD_WIDTH'(sx_reg[STG_M-1]);
        m_uy = sy_reg[STG_M-1][COORD_WIDTH-1] ? COORD_WIDTH'(-sy_reg[STG_M-1])
                                              : COORD_WIDTH'(sy_reg[STG_M-1]);
        r_x  = scale_sat(m_px_reg, sx_reg[STG_M][COORD_WIDTH-1]);
        r_y  = scale_sat(m_py_reg, sy_reg[STG_M][COORD_WIDTH-1]);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i <= STG_M; i++) begin
                vld_reg[i] <= 1'b0;
            end
            res_vld_reg <= 1'b0;
        end else begin
            vld_reg[0] <= accept;
            for (int i = 1; i <= STG_M; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            res_vld_reg <= vld_reg[STG_M];
        end
    end

    // Payload registers of every stage.
    always_ff @(posedge clk)
    begin
        sx_reg[0] <= req.x_in;
        sy_reg[0] <= req.y_in;
        kz_reg[0] <= (kappa == '0);
        for (int i = 1; i <= STG_M; i++) begin
            sx_reg[i] <= sx_reg[i-1];
            sy_reg[i] <= sy_reg[i-1];
            kz_reg[i] <= kz_reg[i-1];
        end
        cl_reg[STG_E] <= e_clamp;
        for (int i = STG_E + 1; i <= STG_M; i++) begin
            cl_reg[i] <= cl_reg[i-1];
        end

        a_kneg_reg  <= req.req_type ^ kappa[KAPPA_WIDTH-1];
        a_kmag_reg  <= in_kmag;
        a_ux_reg    <= in_ux;
        a_uy_reg    <= in_uy;
        b_kneg_reg  <= a_kneg_reg;
        b_kmag_reg  <= a_kmag_reg;
        b_sqx_reg   <= SUMSQ_WIDTH'(a_ux_reg * a_ux_reg);
        b_sqy_reg   <= SUMSQ_WIDTH'(a_uy_reg * a_uy_reg);
        c_kneg_reg  <= b_kneg_reg;
        c_kmag_reg  <= b_kmag_reg;
        c_s24_reg   <= c_s24_next;
        d_kneg_reg  <= c_kneg_reg;
        d_kprod_reg <= KPROD_WIDTH'(c_kmag_reg * c_s24_reg);

        sq_rad_reg[0]  <= RAD_WIDTH'({e_d, {RAD_PRESHIFT{1'b0}}});
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        for (int j = 1; j <= SQ_STEPS; j++) begin
            sq_rad_reg[j]  <= sq_rad_next[j];
            sq_rem_reg[j]  <= sq_rem_next[j];
            sq_root_reg[j] <= sq_root_next[j];
        end

        // Numerator 2^50 + g/2: the high part is a lone one, the low part is g/2.
        dv_rem_reg[0] <= DVREM_WIDTH'(1) << (RECIP_SHIFT - Q_WIDTH);
        dv_num_reg[0] <= Q_WIDTH'(sq_root_reg[SQ_STEPS] >> 1);
        dv_q_reg[0]   <= '0;
        dv_g_reg[0]   <= sq_root_reg[SQ_STEPS];
        for (int j = 1; j <= Q_WIDTH; j++) begin
            dv_rem_reg[j] <= dv_rem_next[j];
            dv_num_reg[j] <= dv_num_next[j];
            dv_q_reg[j]   <= dv_q_next[j];
            dv_g_reg[j]   <= dv_g_reg[j-1];
        end

        m_px_reg <= PROD_WIDTH'(m_ux * dv_q_reg[Q_WIDTH]);
        m_py_reg <= PROD_WIDTH'(m_uy * dv_q_reg[Q_WIDTH]);

        // Output register; zero kappa passes the point through.
        if (kz_reg[STG_M]) begin
            res_reg.x_out           <= sx_reg[STG_M];
            res_reg.y_out           <= sy_reg[STG_M];
            res_reg.radius_clamped  <= 1'b0;
            res_reg.coord_saturated <= 1'b0;
        end else begin
            res_reg.x_out           <= r_x[COORD_WIDTH-1:0];
            res_reg.y_out           <= r_y[COORD_WIDTH-1:0];
            res_reg.radius_clamped  <= cl_reg[STG_M];
            res_reg.coord_saturated <= r_x[COORD_WIDTH] | r_y[COORD_WIDTH];
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

>>> src/radial_distortion_scaler.sv
`timescale 1ns / 1ps
// Radial distortion scaler: kappa register, command port and the scaling pipeline.
//
// A point beat is taken on every cycle in which start is high; busy never rises, so one beat
// per clock is sustained. Each beat gives exactly one result, shown on result for a single
// cycle with result_valid high, in the order taken. The receiver cannot stall: a result that
// is not taken in its one cycle is lost. The latency is set by the bit-serial pipeline: four
// stages for the magnitudes, the squares, their sum and the product with kappa, one stage that
// loads the square root and one per bit of the 31-bit root, one stage that loads the
// reciprocal and one per bit of the 32-bit reciprocal, and two for the final scaling.
// Write kappa over the APB port only while no beat is in flight.
module radial_distortion_scaler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  rds_pkg::req_t                  req,
    output logic                           result_valid,
    output rds_pkg::res_t                  result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rds_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import rds_pkg::*;

    logic signed [KAPPA_WIDTH-1:0] kappa_reg;
    logic                          wr_en;

    // The pipeline never stalls.
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Register write on the access cycle.
    assign wr_en = psel && penable && pwrite && pready && (paddr[2] == REG_KAPPA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kappa_reg <= '0;
        end else if (wr_en) begin
            kappa_reg <= pwdata;
        end
    end

    // Read back.
    assign prdata = (paddr[2] == REG_KAPPA) ? kappa_reg : '0;

    rds_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (start && !busy),
        .req          (req),
        .kappa        (kappa_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

>>> src/rds_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the radial distortion scaler and its bind.
module rds_port_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input rds_pkg::req_t req,
    input logic          result_valid,
    input rds_pkg::res_t result
);
    import rds_pkg::*;

    // The block always takes a beat.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every accepted beat yields one result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("result missing");

    // No result appears without a beat.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !result_valid)
        else $error("result without beat");

    // The origin maps to the origin with no flag set, whatever kappa is.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.x_in == '0 && req.y_in == '0) |-> ##LATENCY
        (result.x_out == '0 && result.y_out == '0 && !result.radius_clamped &&
         !result.coord_saturated))
        else $error("origin not preserved");

endmodule

bind radial_distortion_scaler rds_port_checker u_rds_checker (.*);
